FILE: src/hba_pkg.sv
// Shared types, constants and codes for the heap block allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package hba_pkg;

  localparam int HEAP_BYTES = 1048576;
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_OOM     = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_NEXT  = 2'd3;

  localparam logic [1:0] REG_FIT_MODE = 2'd0;
  localparam logic [1:0] REG_HEADER   = 2'd1;

  localparam logic [6:0] HDR_RESET = 7'd24;
  localparam logic [6:0] HDR_MIN   = 7'd8;
  localparam logic [6:0] HDR_MAX   = 7'd64;

  typedef struct packed {
    logic [19:0] data;
    logic [20:0] size;
    logic        free;
  } entry_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_PICK,
    OP_SHIFT,
    OP_SPLITW,
    OP_WRA,
    OP_PEAK,
    OP_GROW,
    OP_MARK,
    OP_RCHK,
    OP_LCHK,
    OP_BAD,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic triv;
    logic is_alloc;
    logic scan_done;
    logic found;
    logic a_free;
    logic split_ok;
    logic grow_ok;
    logic right_ok;
    logic left_ok;
    logic nb_free;
    logic shift_done;
    logic out_free;
  } dp_status_t;

endpackage

FILE: src/heap_block_allocator.sv
// Heap block allocator: keeps an address-ordered table of heap blocks and serves
// allocate and free items, one at a time.
// Channels: the input channel (in_valid, in_stall, cmd, request_size, block_addr)
// takes an item when in_valid is high and in_stall is low. The output channel
// (out_valid, out_stall, status, data_addr, was_split, was_grown, merges_done,
// peak_bytes) delivers one result per item when out_valid is high and out_stall low.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// fit_mode at index 0 and header_bytes at index 1; cfg_ready is always high.
// The table scan reads the entries one by one through the single read port of the
// block table; a split, or the merges of a free, also shifts table entries through
// that port, one entry at a time.
// A new item is taken as soon as the previous one has left the sequencer, while
// its result may still wait in the output register.
// When the receiver stalls, the result stays in the output register and the
// following item finishes its work, then waits until the register is free.
// Reset (rst, synchronous) empties the table, zeroes heap top and peak, forgets
// the next-fit position, and sets fit_mode to 0 and header_bytes to 24.
module heap_block_allocator
  import hba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [20:0] request_size,
  input  logic [19:0] block_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [19:0] data_addr,
  output logic        was_split,
  output logic        was_grown,
  output logic [1:0]  merges_done,
  output logic [20:0] peak_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  op_t        op;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  hba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .op       (op)
  );

  hba_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .st           (st),
    .cmd          (cmd),
    .request_size (request_size),
    .block_addr   (block_addr),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .data_addr    (data_addr),
    .was_split    (was_split),
    .was_grown    (was_grown),
    .merges_done  (merges_done),
    .peak_bytes   (peak_bytes)
  );

endmodule

FILE: src/hba_ram.sv
// Generic single-write, single-read memory with registered read data.
// Stand-alone; no package dependencies.
module hba_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/hba_ctrl.sv
// Sequencer for the heap block allocator: one state machine issuing datapath operations.
// Depends on hba_pkg for the operation codes and the datapath status struct.
module hba_ctrl
  import hba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t st,
  output op_t        op
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SCAN, S_PICK, S_SPLITW, S_WRA, S_PEAK, S_GROW,
    S_MARK, S_RCHK, S_FWA, S_LCHK, S_SHIFT, S_BAD, S_FIN
  } state_t;

  state_t state, state_next, ret, ret_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ret_next   = ret;
    op         = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: state_next = st.triv ? S_FIN : S_SCAN;
      S_SCAN: begin
        op = OP_SCAN;
        if (st.scan_done) begin
          if (st.is_alloc) begin
            state_next = st.found ? S_PICK : S_GROW;
          end else begin
            state_next = (st.found && !st.a_free) ? S_MARK : S_BAD;
          end
        end
      end
      S_PICK: begin
        op = OP_PICK;
        if (st.split_ok) begin
          state_next = S_SHIFT;
          ret_next   = S_SPLITW;
        end else begin
          state_next = S_WRA;
        end
      end
      S_SPLITW: begin
        op         = OP_SPLITW;
        state_next = S_WRA;
      end
      S_WRA: begin
        op         = OP_WRA;
        state_next = S_PEAK;
      end
      S_PEAK: begin
        op         = OP_PEAK;
        state_next = S_FIN;
      end
      S_GROW: begin
        op         = OP_GROW;
        state_next = st.grow_ok ? S_PEAK : S_FIN;
      end
      S_MARK: begin
        op         = OP_MARK;
        state_next = st.right_ok ? S_RCHK : S_FWA;
      end
      S_RCHK: begin
        op         = OP_RCHK;
        state_next = st.nb_free ? S_SHIFT : S_FWA;
        ret_next   = S_FWA;
      end
      S_FWA: begin
        op         = OP_WRA;
        state_next = st.left_ok ? S_LCHK : S_FIN;
      end
      S_LCHK: begin
        op         = OP_LCHK;
        state_next = st.nb_free ? S_SHIFT : S_FIN;
        ret_next   = S_FIN;
      end
      S_SHIFT: begin
        op = OP_SHIFT;
        if (st.shift_done) begin
          state_next = ret;
        end
      end
      S_BAD: begin
        op         = OP_BAD;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          op         = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

endmodule

FILE: src/hba_datapath.sv
// Datapath of the heap block allocator: block table memory, heap registers and result registers.
// Depends on hba_pkg and hba_ram; driven by hba_ctrl, which issues at most one operation per cycle.
module hba_datapath
  import hba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  op_t         op,
  output dp_status_t  st,
  input  logic        cmd,
  input  logic [20:0] request_size,
  input  logic [19:0] block_addr,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [19:0] data_addr,
  output logic        was_split,
  output logic        was_grown,
  output logic [1:0]  merges_done,
  output logic [20:0] peak_bytes
);

  logic [1:0]       fit_mode;
  logic [6:0]       header_bytes;
  logic             cmd_r;
  logic [21:0]      need;
  logic [19:0]      target;
  logic [6:0]       hdr;
  logic [CNT_W-1:0] cnt;
  logic [20:0]      top;
  logic [IDX_W-1:0] rover;
  logic             rover_v;
  logic [20:0]      peak;
  logic [20:0]      total;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] steps;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;
  logic             found_v;
  logic [IDX_W-1:0] found;
  logic [20:0]      best;
  entry_t           ent_a, ent_b;
  logic [IDX_W-1:0] sh_src, sh_dst;
  logic [CNT_W-1:0] sh_num;
  logic             sh_up, sh_pend;
  logic [1:0]       res_status;
  logic [19:0]      res_addr;
  logic             res_split, res_grown;
  logic [1:0]       res_merges;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, rd;
  logic [$bits(entry_t)-1:0] ram_rbits;

  logic             rover_ok, fits, take, split_ok, grow_ok;
  logic [22:0]      req_round;
  logic [21:0]      need_in;
  logic [6:0]       hdr_in;
  logic [20:0]      left;
  logic [22:0]      grow_sum;
  logic [20:0]      grow_base;
  logic [21:0]      rsz, lsz, rtot, ltot;
  logic [IDX_W-1:0] found_p1, found_m1, idx_p1;
  logic [CNT_W-1:0] cnt_m1;

  function automatic logic [IDX_W-1:0] rover_adj(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] j);
    logic [IDX_W-1:0] res;
    res = r;
    if (r == j) begin
      res = (j != '0) ? j - 1'b1 : '0;
    end else if (r > j) begin
      res = r - 1'b1;
    end
    return res;
  endfunction

  hba_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_BLOCKS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  assign rd = entry_t'(ram_rbits);

  always_comb begin
    req_round = {2'b0, request_size} + 23'd3;
    need_in   = {req_round[21:2], 2'b00};
    if (header_bytes < HDR_MIN) begin
      hdr_in = HDR_MIN;
    end else if (header_bytes > HDR_MAX) begin
      hdr_in = HDR_MAX;
    end else begin
      hdr_in = header_bytes;
    end
  end

  assign rover_ok  = rover_v && ({1'b0, rover} < cnt);
  assign found_p1  = found + 1'b1;
  assign found_m1  = found - 1'b1;
  assign idx_p1    = idx + 1'b1;
  assign cnt_m1    = cnt - 1'b1;
  assign fits      = rd.free && ({1'b0, rd.size} >= need);
  assign left      = ent_a.size - need[20:0];
  assign split_ok  = (left > {14'b0, hdr + 7'd4}) && (cnt != CNT_W'(MAX_BLOCKS));
  assign grow_sum  = {2'b0, top} + {16'b0, hdr} + {1'b0, need};
  assign grow_ok   = (cnt != CNT_W'(MAX_BLOCKS)) && (grow_sum <= 23'(HEAP_BYTES));
  assign grow_base = top + {14'b0, hdr};
  assign rsz  = {2'b0, rd.data} + {1'b0, rd.size} - {2'b0, ent_a.data};
  assign lsz  = {2'b0, ent_a.data} + {1'b0, ent_a.size} - {2'b0, rd.data};
  assign rtot = {1'b0, total} + rsz - {1'b0, ent_a.size} - {1'b0, rd.size};
  assign ltot = {1'b0, total} + lsz - {1'b0, ent_a.size} - {1'b0, rd.size};

  always_comb begin
    if (cmd_r == CMD_ALLOC) begin
      case (fit_mode)
        FIT_BEST:  take = fits && (!found_v || (rd.size < best));
        FIT_WORST: take = fits && (!found_v || (rd.size > best));
        default:   take = fits && !found_v;
      endcase
    end else begin
      take = (rd.data == target) && !found_v;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = found;
    ram_wdata = ent_a;
    ram_raddr = idx;
    case (op)
      OP_SCAN:  ram_raddr = idx;
      OP_SHIFT: begin
        ram_raddr = sh_src;
        ram_we    = sh_pend;
        ram_waddr = sh_dst;
        ram_wdata = rd;
      end
      OP_SPLITW: begin
        ram_we    = 1'b1;
        ram_waddr = found_p1;
        ram_wdata = ent_b;
      end
      OP_WRA: begin
        ram_we    = 1'b1;
        ram_raddr = found_m1;
      end
      OP_GROW: begin
        ram_we    = grow_ok;
        ram_waddr = cnt[IDX_W-1:0];
        ram_wdata = '{data: grow_base[19:0], size: need[20:0], free: 1'b0};
      end
      OP_MARK:  ram_raddr = found_p1;
      OP_LCHK: begin
        ram_we    = rd.free;
        ram_waddr = found_m1;
        ram_wdata = '{data: rd.data, size: lsz[20:0], free: 1'b1};
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    st.triv       = (cmd_r == CMD_ALLOC) ? (need == '0) : (target == '0);
    st.is_alloc   = (cmd_r == CMD_ALLOC);
    st.scan_done  = (steps == cnt) && !rd_pend;
    st.found      = found_v;
    st.a_free     = ent_a.free;
    st.split_ok   = split_ok;
    st.grow_ok    = grow_ok;
    st.right_ok   = ({1'b0, found} + 1'b1) < cnt;
    st.left_ok    = (found != '0);
    st.nb_free    = rd.free;
    st.shift_done = (sh_num == '0) && !sh_pend;
    st.out_free   = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode     <= FIT_FIRST;
      header_bytes <= HDR_RESET;
      cnt          <= '0;
      top          <= '0;
      rover        <= '0;
      rover_v      <= 1'b0;
      peak         <= '0;
      total        <= '0;
      rd_pend      <= 1'b0;
      sh_pend      <= 1'b0;
      sh_num       <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == REG_FIT_MODE) begin
        fit_mode <= cfg_data[1:0];
      end
      if (cfg_valid && cfg_index == REG_HEADER) begin
        header_bytes <= cfg_data;
      end
      if (out_valid && !out_stall && op != OP_EMIT) begin
        out_valid <= 1'b0;
      end
      case (op)
        OP_LOAD: begin
          cmd_r      <= cmd;
          need       <= need_in;
          target     <= block_addr;
          hdr        <= hdr_in;
          steps      <= '0;
          rd_pend    <= 1'b0;
          found_v    <= 1'b0;
          res_status <= (cmd == CMD_ALLOC && request_size == '0) ? ST_ZERO : ST_OK;
          res_addr   <= '0;
          res_split  <= 1'b0;
          res_grown  <= 1'b0;
          res_merges <= '0;
          if (cmd == CMD_ALLOC && request_size != '0 && fit_mode == FIT_NEXT) begin
            if (rover_ok) begin
              idx <= rover;
            end else begin
              idx     <= '0;
              rover_v <= 1'b0;
            end
          end else begin
            idx <= '0;
          end
        end
        OP_SCAN: begin
          if (rd_pend && take) begin
            found_v <= 1'b1;
            found   <= rd_idx;
            ent_a   <= rd;
            best    <= rd.size;
          end
          if (steps != cnt) begin
            rd_pend <= 1'b1;
            rd_idx  <= idx;
            idx     <= ({1'b0, idx_p1} == cnt) ? '0 : idx_p1;
            steps   <= steps + 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
        end
        OP_PICK: begin
          res_addr <= ent_a.data;
          if (fit_mode == FIT_NEXT) begin
            rover   <= found;
            rover_v <= 1'b1;
          end
          ent_a.free <= 1'b0;
          if (split_ok) begin
            ent_a.size <= need[20:0];
          end
          ent_b   <= '{data: ent_a.data + need[19:0] + {13'b0, hdr},
                       size: left - {14'b0, hdr}, free: 1'b1};
          sh_src  <= cnt_m1[IDX_W-1:0];
          sh_num  <= cnt_m1 - {1'b0, found};
          sh_up   <= 1'b1;
          sh_pend <= 1'b0;
        end
        OP_SHIFT: begin
          if (sh_num != '0) begin
            sh_pend <= 1'b1;
            sh_dst  <= sh_up ? sh_src + 1'b1 : sh_src - 1'b1;
            sh_src  <= sh_up ? sh_src - 1'b1 : sh_src + 1'b1;
            sh_num  <= sh_num - 1'b1;
          end else begin
            sh_pend <= 1'b0;
          end
        end
        OP_SPLITW: begin
          cnt       <= cnt + 1'b1;
          total     <= total - {14'b0, hdr};
          res_split <= 1'b1;
          if (rover_v && rover > found) begin
            rover <= rover + 1'b1;
          end
        end
        OP_PEAK: begin
          if (total > peak) begin
            peak <= total;
          end
        end
        OP_GROW: begin
          if (fit_mode == FIT_NEXT) begin
            rover_v <= 1'b0;
          end
          if (grow_ok) begin
            res_addr  <= grow_base[19:0];
            top       <= grow_sum[20:0];
            cnt       <= cnt + 1'b1;
            total     <= total + need[20:0];
            res_grown <= 1'b1;
          end else begin
            res_status <= ST_OOM;
          end
        end
        OP_MARK: ent_a.free <= 1'b1;
        OP_RCHK: begin
          if (rd.free) begin
            ent_a.size <= rsz[20:0];
            total      <= rtot[20:0];
            res_merges <= res_merges + 1'b1;
            cnt        <= cnt_m1;
            if (rover_v) begin
              rover <= rover_adj(rover, found_p1);
            end
            sh_src  <= found + 2'd2;
            sh_num  <= cnt - {1'b0, found} - 2'd2;
            sh_up   <= 1'b0;
            sh_pend <= 1'b0;
          end
        end
        OP_LCHK: begin
          if (rd.free) begin
            total      <= ltot[20:0];
            res_merges <= res_merges + 1'b1;
            cnt        <= cnt_m1;
            if (rover_v) begin
              rover <= rover_adj(rover, found);
            end
            sh_src  <= found_p1;
            sh_num  <= cnt_m1 - {1'b0, found};
            sh_up   <= 1'b0;
            sh_pend <= 1'b0;
          end
        end
        OP_BAD: res_status <= ST_BADFREE;
        OP_EMIT: begin
          out_valid   <= 1'b1;
          status      <= res_status;
          data_addr   <= res_addr;
          was_split   <= res_split;
          was_grown   <= res_grown;
          merges_done <= res_merges;
          peak_bytes  <= peak;
        end
        default: begin
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_BLOCKS))
    else $error("block count exceeds table depth");

  a_rover_in_table: assert property (@(posedge clk) disable iff (rst)
    rover_v |-> ({1'b0, rover} < cnt))
    else $error("remembered block lies beyond the table");

  a_peak_covers: assert property (@(posedge clk) disable iff (rst)
    op == OP_PEAK |=> peak >= total)
    else $error("peak below current total after an allocation");

  a_top_limit: assert property (@(posedge clk) disable iff (rst)
    top <= 21'(HEAP_BYTES))
    else $error("heap top beyond heap size");

endmodule

FILE: sim/tb_heap_block_allocator.sv
// Self-checking testbench for the heap block allocator: a directed table, then random
// allocate/free traffic under several placement policies, checked by an in-bench predictor.
// Depends on hba_pkg and heap_block_allocator only.
module tb_heap_block_allocator
  import hba_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        cmd;
    logic [20:0] request_size;
    logic [19:0] block_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] data_addr;
    logic        was_split;
    logic        was_grown;
    logic [1:0]  merges_done;
    logic [20:0] peak_bytes;
  } rsp_t;

  typedef struct {
    req_t req;
    logic typed;
    rsp_t rsp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_stall;
  logic cmd = 1'b0;
  logic [20:0] request_size = '0;
  logic [19:0] block_addr = '0;
  logic out_valid, out_stall = 1'b0;
  logic [1:0] status;
  logic [19:0] data_addr;
  logic was_split, was_grown;
  logic [1:0] merges_done;
  logic [20:0] peak_bytes;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  heap_block_allocator DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [19:0] blk_data [MAX_BLOCKS];
  logic [20:0] blk_size [MAX_BLOCKS];
  logic        blk_free [MAX_BLOCKS];
  int   blk_cnt, top, rov, peak;
  logic rov_ok;
  logic [1:0] fit_sel;
  logic [6:0] hdr_reg;

  rsp_t expected_q[$];
  int errors, accepted, results;
  int send_idle, recv_idle;
  int hold_off = 0;
  int hold_len = 0;
  logic hold_seen = 1'b0;
  logic [19:0] live_q[$];

  task automatic report(string what, rsp_t got, rsp_t exp);
    errors++;
    $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, exp);
  endtask

  function automatic int hdr_eff();
    if (hdr_reg < HDR_MIN) return HDR_MIN;
    if (hdr_reg > HDR_MAX) return HDR_MAX;
    return hdr_reg;
  endfunction

  function automatic bit fits_at(int i, int need);
    return blk_free[i] && blk_size[i] >= need;
  endfunction

  function automatic int first_fit(int need);
    for (int i = 0; i < blk_cnt; i++) if (fits_at(i, need)) return i;
    return -1;
  endfunction

  function automatic int choose_block(int need);
    int found, best, j;
    found = -1;
    best = 0;
    case (fit_sel)
      FIT_FIRST: return first_fit(need);
      FIT_BEST, FIT_WORST: begin
        for (int i = 0; i < blk_cnt; i++) begin
          if (fits_at(i, need)) begin
            if (found < 0 || (fit_sel == FIT_BEST ? blk_size[i] - need < best
                                                 : blk_size[i] - need > best)) begin
              best = blk_size[i] - need;
              found = i;
            end
          end
        end
        return found;
      end
      default: begin
        if (!rov_ok || rov >= blk_cnt) begin
          rov_ok = 1'b0;
          found = first_fit(need);
          if (found >= 0) begin
            rov = found;
            rov_ok = 1'b1;
          end
          return found;
        end
        for (int i = 0; i < blk_cnt; i++) begin
          j = rov + i;
          if (j >= blk_cnt) j -= blk_cnt;
          if (fits_at(j, need)) begin
            rov = j;
            return j;
          end
        end
        rov_ok = 1'b0;
        return -1;
      end
    endcase
  endfunction

  function automatic void drop_entry(int j);
    for (int k = j; k < blk_cnt - 1; k++) begin
      blk_data[k] = blk_data[k + 1];
      blk_size[k] = blk_size[k + 1];
      blk_free[k] = blk_free[k + 1];
    end
    blk_cnt--;
    if (rov_ok) begin
      if (rov == j) rov = (j > 0) ? j - 1 : 0;
      else if (rov > j) rov--;
    end
  endfunction

  function automatic rsp_t predict_heap(req_t r);
    rsp_t o;
    int hdr, need, f, left, sum, hit;
    o = '0;
    hdr = hdr_eff();
    if (r.cmd == CMD_ALLOC) begin
      if (r.request_size == 0) begin
        o.status = ST_ZERO;
      end else begin
        need = (int'(r.request_size) + 3) & ~3;
        f = choose_block(need);
        if (f >= 0) begin
          left = blk_size[f] - need;
          if (left > hdr + 4 && blk_cnt < MAX_BLOCKS) begin
            for (int k = blk_cnt; k > f + 1; k--) begin
              blk_data[k] = blk_data[k - 1];
              blk_size[k] = blk_size[k - 1];
              blk_free[k] = blk_free[k - 1];
            end
            blk_data[f + 1] = 20'(blk_data[f] + need + hdr);
            blk_size[f + 1] = 21'(left - hdr);
            blk_free[f + 1] = 1'b1;
            blk_size[f] = 21'(need);
            blk_cnt++;
            if (rov_ok && rov > f) rov++;
            o.was_split = 1'b1;
          end
          blk_free[f] = 1'b0;
          o.data_addr = blk_data[f];
        end else if (blk_cnt >= MAX_BLOCKS || top + hdr + need > HEAP_BYTES) begin
          o.status = ST_OOM;
        end else begin
          blk_data[blk_cnt] = 20'(top + hdr);
          blk_size[blk_cnt] = 21'(need);
          blk_free[blk_cnt] = 1'b0;
          o.data_addr = 20'(top + hdr);
          top += hdr + need;
          blk_cnt++;
          o.was_grown = 1'b1;
        end
        if (o.status == ST_OK) begin
          sum = 0;
          for (int i = 0; i < blk_cnt; i++) sum += blk_size[i];
          if (sum > 21'h1FFFFF) sum = 21'h1FFFFF;
          if (sum > peak) peak = sum;
        end
      end
    end else if (r.block_addr != 0) begin
      hit = -1;
      for (int i = 0; i < blk_cnt; i++) begin
        if (hit < 0 && blk_data[i] == r.block_addr) hit = i;
      end
      if (hit < 0 || blk_free[hit]) begin
        o.status = ST_BADFREE;
      end else begin
        blk_free[hit] = 1'b1;
        if (hit + 1 < blk_cnt && blk_free[hit + 1]) begin
          blk_size[hit] = blk_data[hit + 1] + blk_size[hit + 1] - blk_data[hit];
          drop_entry(hit + 1);
          o.merges_done++;
        end
        if (hit > 0 && blk_free[hit - 1]) begin
          blk_size[hit - 1] = blk_data[hit] + blk_size[hit] - blk_data[hit - 1];
          drop_entry(hit);
          o.merges_done++;
        end
      end
    end
    if (o.status != ST_OK) o.data_addr = '0;
    o.peak_bytes = 21'(peak);
    return o;
  endfunction

  task automatic send_item(req_t r, logic typed = 1'b0, rsp_t typed_rsp = '0);
    rsp_t p;
    if (in_valid) @(negedge clk);
    while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk);
    in_valid <= 1'b1;
    cmd <= r.cmd;
    request_size <= r.request_size;
    block_addr <= r.block_addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_heap(r);
    if (typed && p != typed_rsp) report("typed row vs predictor", p, typed_rsp);
    expected_q.push_back(p);
    if (r.cmd == CMD_ALLOC && p.status == ST_OK) live_q.push_back(p.data_addr);
    accepted++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    if (cfg_valid) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_FIT_MODE) fit_sel = val[1:0];
    else hdr_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (2 * MAX_BLOCKS + 20) @(negedge clk);
  endtask

  always @(posedge clk) begin
    rsp_t got, exp;
    if (!rst && out_valid && !out_stall) begin
      got = {status, data_addr, was_split, was_grown, merges_done, peak_bytes};
      results++;
      if (expected_q.size() == 0) begin
        report("unexpected result", got, '0);
      end else begin
        exp = expected_q.pop_front();
        if (got.status != exp.status) report("status", got, exp);
        if (got.data_addr != exp.data_addr) report("data_addr", got, exp);
        if (got.was_split != exp.was_split) report("was_split", got, exp);
        if (got.was_grown != exp.was_grown) report("was_grown", got, exp);
        if (got.merges_done != exp.merges_done) report("merges_done", got, exp);
        if (got.peak_bytes != exp.peak_bytes) report("peak_bytes", got, exp);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_len != 0 && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_off <= hold_len - 1;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
    end
  end

  function automatic req_t random_item();
    req_t r;
    int k, pick;
    r.request_size = '0;
    r.block_addr = 20'($urandom);
    pick = $urandom_range(99);
    if (pick < 48) begin
      r.cmd = CMD_ALLOC;
      case ($urandom_range(9))
        0: r.request_size = 21'($urandom_range(21'h1FFFFF));
        1: r.request_size = '0;
        2, 3: r.request_size = 21'($urandom_range(20000, 1));
        default: r.request_size = 21'($urandom_range(600, 1));
      endcase
    end else if (pick < 92 && live_q.size() != 0) begin
      r.cmd = CMD_FREE;
      k = $urandom_range(live_q.size() - 1);
      r.block_addr = live_q[k];
      live_q.delete(k);
    end else begin
      r.cmd = CMD_FREE;
      if ($urandom_range(3) == 0) r.block_addr = '0;
      else if ($urandom_range(1) == 0 && blk_cnt != 0)
        r.block_addr = blk_data[$urandom_range(blk_cnt - 1)];
    end
    return r;
  endfunction

  row_t dir_rows[$];

  function automatic row_t mk(logic c, int sz, int ad, logic t = 1'b0, rsp_t e = '0);
    row_t w;
    w.req = '{cmd: c, request_size: 21'(sz), block_addr: 20'(ad)};
    w.typed = t;
    w.rsp = e;
    return w;
  endfunction

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int phase;
    blk_cnt = 0; top = 0; rov = 0; rov_ok = 1'b0; peak = 0;
    fit_sel = FIT_FIRST; hdr_reg = HDR_RESET;
    errors = 0; accepted = 0; results = 0;
    send_idle = 0; recv_idle = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    dir_rows.push_back(mk(CMD_ALLOC, 0, 0, 1'b1,
                          '{ST_ZERO, 20'd0, 1'b0, 1'b0, 2'd0, 21'd0}));
    dir_rows.push_back(mk(CMD_FREE, 0, 20'hFFFFF, 1'b1,
                          '{ST_BADFREE, 20'd0, 1'b0, 1'b0, 2'd0, 21'd0}));
    dir_rows.push_back(mk(CMD_FREE, 0, 0, 1'b1,
                          '{ST_OK, 20'd0, 1'b0, 1'b0, 2'd0, 21'd0}));
    dir_rows.push_back(mk(CMD_ALLOC, 21'h100000, 0, 1'b1,
                          '{ST_OOM, 20'd0, 1'b0, 1'b0, 2'd0, 21'd0}));
    dir_rows.push_back(mk(CMD_ALLOC, 21'h1FFFFF, 0, 1'b1,
                          '{ST_OOM, 20'd0, 1'b0, 1'b0, 2'd0, 21'd0}));
    dir_rows.push_back(mk(CMD_ALLOC, 1, 0, 1'b1,
                          '{ST_OK, 20'd24, 1'b0, 1'b1, 2'd0, 21'd4}));
    dir_rows.push_back(mk(CMD_ALLOC, 400, 0));
    dir_rows.push_back(mk(CMD_ALLOC, 100, 0));
    dir_rows.push_back(mk(CMD_ALLOC, 1000, 0));
    dir_rows.push_back(mk(CMD_ALLOC, 7, 0));
    dir_rows.push_back(mk(CMD_FREE, 0, 24, 1'b1,
                          '{ST_OK, 20'd0, 1'b0, 1'b0, 2'd0, 21'd1512}));
    dir_rows.push_back(mk(CMD_FREE, 0, 24, 1'b1,
                          '{ST_BADFREE, 20'd0, 1'b0, 1'b0, 2'd0, 21'd1512}));
    dir_rows.push_back(mk(CMD_FREE, 0, 52, 0));
    dir_rows.push_back(mk(CMD_FREE, 0, 576, 0));
    dir_rows.push_back(mk(CMD_FREE, 0, 476, 0));
    dir_rows.push_back(mk(CMD_ALLOC, 50, 0));
    dir_rows.push_back(mk(CMD_ALLOC, 1048000, 0));
    dir_rows.push_back(mk(CMD_FREE, 0, 13, 0));
    for (int i = 0; i < dir_rows.size(); i++)
      send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
    drain();

    for (phase = 0; phase < 9; phase++) begin
      write_reg(REG_FIT_MODE, 7'(phase % 4));
      case (phase)
        1: write_reg(REG_HEADER, HDR_MIN);
        3: write_reg(REG_HEADER, HDR_MAX);
        5: write_reg(REG_HEADER, 7'd0);
        6: write_reg(REG_HEADER, 7'h7F);
        8: write_reg(REG_HEADER, 7'(4 * $urandom_range(16, 2)));
        default: ;
      endcase
      send_idle = (phase < 3) ? 29 : (phase < 6) ? 65 : 0;
      recv_idle = (phase < 3) ? 65 : (phase < 6) ? 29 : 0;
      for (int n = 0; n < 150; n++) begin
        if (phase == 7 && n == 20) hold_len = 400;
        if (phase == 4 && n == 75) while (expected_q.size() != 0) @(negedge clk);
        send_item(random_item());
      end
      drain();
    end

    $display("Run covered %0d items and %0d results over four fit policies and header sizes.",
             accepted, results);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
